// ===== hdl/vcg_pkg.sv =====
`timescale 1ns / 1ps
package vcg_pkg;

    localparam int COORD_W = 32;
    localparam int FREQ_W  = 30;
    localparam int SCALE_W = 48;
    localparam int SUM_W   = 64;
    localparam int WSUM_W  = 48;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 48'd1833000000;

    localparam logic [1:0] ST_ACCUM   = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_READ    = 2'd2;

    // signed 64-bit sum plus signed addend, clamped to the signed limits
    function automatic logic signed [SUM_W-1:0] sat_add64(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            sat_add64 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sat_add64 = s[SUM_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/visibility_cell_gridder.sv =====
`timescale 1ns / 1ps
// Accumulate: 3-step scale multiply, read, add/write, then result; a dropped word skips read and add/write.
// Read: cell read, then result with zero weight or outside the grid; a nonzero weight adds a divide by the weight.
// One word in flight; next word taken the cycle after its result is loaded, and a
// result held in the output register does not block the next word.
// Reset: clearing pass over all GRID_SIDE*GRID_SIDE cells, one cell a cycle, before
// the first word is taken; scale_reg resets to 1833000000.
module visibility_cell_gridder
    import vcg_pkg::*;
#(
    parameter int GRID_SIDE = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      func,
    input  logic signed [31:0]        u_meters,
    input  logic signed [31:0]        v_meters,
    input  logic [29:0]               freq_khz,
    input  logic signed [31:0]        vis_real,
    input  logic signed [31:0]        vis_imag,
    input  logic [31:0]               vis_weight,
    input  logic [7:0]                read_row,
    input  logic [7:0]                read_col,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [47:0]               cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                status,
    output logic signed [63:0]        avg_real,
    output logic signed [63:0]        avg_imag,
    output logic [47:0]               cell_weight
);
    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CELLS  = GRID_SIDE * GRID_SIDE;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_MAP   = 8'b00000100,
        S_RD    = 8'b00001000,
        S_UPD   = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_RDWT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [SCALE_W-1:0] scale_reg;
    logic [ADDR_W:0]    clr_reg;
    logic               func_reg;
    logic signed [31:0] re_reg, im_reg;
    logic [31:0]        w_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               rd_ok_reg;

    logic [1:0]              res_st_reg;
    logic signed [SUM_W-1:0] res_re_reg, res_im_reg;
    logic [WSUM_W-1:0]       res_w_reg;
    logic                    out_load;

    logic signed [SUM_W-1:0] mem_re [CELLS];
    logic signed [SUM_W-1:0] mem_im [CELLS];
    logic [WSUM_W-1:0]       mem_w  [CELLS];
    logic signed [SUM_W-1:0] q_re, q_im;
    logic [WSUM_W-1:0]       q_w;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic signed [SUM_W-1:0] wd_re, wd_im;
    logic [WSUM_W-1:0]  wd_w;

    logic map_start, u_done, v_done, u_in, v_in;
    logic [IDX_W-1:0] u_cell, v_cell;
    logic div_start, dre_done, dim_done;
    logic signed [SUM_W-1:0] dq_re, dq_im;
    logic [48:0] wsum;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign map_start = in_valid && in_ready && !func;
    // result moves to the output register once that register is free
    assign out_load  = (state_reg == S_OUT) && (!out_valid || out_ready);

    vcg_cell_map #(.GRID_SIDE(GRID_SIDE)) u_map (
        .clk, .rst_n, .start(map_start), .coord(u_meters), .freq(freq_khz),
        .scale(scale_reg), .done(u_done), .in_grid(u_in), .cell_idx(u_cell));
    vcg_cell_map #(.GRID_SIDE(GRID_SIDE)) v_map (
        .clk, .rst_n, .start(map_start), .coord(v_meters), .freq(freq_khz),
        .scale(scale_reg), .done(v_done), .in_grid(v_in), .cell_idx(v_cell));

    assign div_start = (state_reg == S_RDWT) && rd_ok_reg && q_w != '0;
    vcg_divider u_div_re (.clk, .rst_n, .start(div_start), .dividend(q_re),
        .divisor(q_w), .done(dre_done), .quotient(dq_re));
    vcg_divider u_div_im (.clk, .rst_n, .start(div_start), .dividend(q_im),
        .divisor(q_w), .done(dim_done), .quotient(dq_im));

    assign wsum = 49'(q_w) + 49'(w_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_reg;
        wd_re = sat_add64(q_re, 64'(signed'({1'b0, w_reg}) * re_reg));
        wd_im = sat_add64(q_im, 64'(signed'({1'b0, w_reg}) * im_reg));
        wd_w  = wsum[48] ? {WSUM_W{1'b1}} : wsum[47:0];
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg[ADDR_W-1:0];
            wd_re = '0;
            wd_im = '0;
            wd_w  = '0;
        end
        else if (state_reg == S_UPD)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_re[waddr] <= wd_re;
            mem_im[waddr] <= wd_im;
            mem_w[waddr]  <= wd_w;
        end
        q_re <= mem_re[addr_reg];
        q_im <= mem_im[addr_reg];
        q_w  <= mem_w[addr_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == ADDR_W'(CELLS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid && in_ready)
                    state_next = func ? S_RD : S_MAP;
            end
            S_MAP:
            begin
                if (u_done)
                    state_next = (u_in && v_in) ? S_RD : S_OUT;
            end
            S_RD:    state_next = func_reg ? S_RDWT : S_UPD;
            S_RDWT:  state_next = div_start ? S_DIV : S_OUT;
            S_UPD:   state_next = S_OUT;
            S_DIV:   if (dre_done) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            scale_reg <= SCALE_RESET;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_valid)
                scale_reg <= cfg_data;
            if (out_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            re_reg    <= vis_real;
            im_reg    <= vis_imag;
            w_reg     <= vis_weight;
            rd_ok_reg <= (16'(read_row) < 16'(GRID_SIDE)) && (16'(read_col) < 16'(GRID_SIDE));
            addr_reg  <= {IDX_W'(read_row), IDX_W'(read_col)};
            res_st_reg <= func ? ST_READ : ST_ACCUM;
            res_re_reg <= '0;
            res_im_reg <= '0;
            res_w_reg  <= '0;
        end
        if (state_reg == S_MAP && u_done)
        begin
            addr_reg <= {u_cell, v_cell};
            if (!(u_in && v_in))
                res_st_reg <= ST_DROPPED;
        end
        if (state_reg == S_RDWT && rd_ok_reg)
        begin
            res_re_reg <= q_re;
            res_im_reg <= q_im;
            res_w_reg  <= q_w;
        end
        if (state_reg == S_DIV && dre_done && dim_done)
        begin
            res_re_reg <= dq_re;
            res_im_reg <= dq_im;
        end
        if (out_load)
        begin
            status      <= res_st_reg;
            avg_real    <= res_re_reg;
            avg_imag    <= res_im_reg;
            cell_weight <= res_w_reg;
        end
    end
endmodule

// ===== hdl/vcg_cell_map.sv =====
`timescale 1ns / 1ps
// Coordinate to cell: |coord|*freq (62b), times scale split in 3 16-bit
// slices taken in turn, shifted 78 with round half up on magnitude.
module vcg_cell_map
    import vcg_pkg::*;
#(
    parameter int GRID_SIDE = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] coord,
    input  logic [FREQ_W-1:0]         freq,
    input  logic [SCALE_W-1:0]        scale,
    output logic                      done,
    output logic                      in_grid,
    output logic [$clog2(GRID_SIDE)-1:0] cell_idx
);
    localparam int IDX_W = $clog2(GRID_SIDE);

    logic [2:0]  step_reg, step_next;
    logic        neg_reg;
    logic [61:0] mf_reg;
    logic [111:0] acc_reg, acc_next;
    logic [32:0] mag;
    logic [15:0] slice;
    logic [77:0] part;
    logic [33:0] cells;
    logic signed [35:0] sc;

    assign mag = coord[COORD_W-1] ? 33'(-{coord[COORD_W-1], coord})
                                  : 33'({1'b0, coord});

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    slice = scale[15:0];
            2'd1:    slice = scale[31:16];
            default: slice = scale[47:32];
        endcase
        part = mf_reg * slice;
        acc_next = acc_reg;
        step_next = step_reg;
        if (step_reg[2])
        begin
            unique case (step_reg[1:0])
                2'd0:    acc_next = 112'(part);
                2'd1:    acc_next = acc_reg + (112'(part) << 16);
                default: acc_next = acc_reg + (112'(part) << 32);
            endcase
            step_next = (step_reg[1:0] == 2'd2) ? 3'd0 : step_reg + 3'd1;
        end
        if (start)
            step_next = 3'b100;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            done     <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done     <= step_reg == 3'b110;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= coord[COORD_W-1];
            mf_reg  <= 62'(mag[31:0] * freq) | (mag[32] ? 62'(freq) << 32 : 62'd0);
        end
        acc_reg <= acc_next;
    end

    assign cells = 34'((acc_reg[111:64] + 48'd8192) >> 14);
    assign sc = (neg_reg ? -36'(cells) : 36'(cells)) + 36'(GRID_SIDE / 2);
    assign in_grid = (sc >= 0) && (sc < 36'(GRID_SIDE));
    assign cell_idx = sc[IDX_W-1:0];
endmodule

// ===== hdl/vcg_divider.sv =====
`timescale 1ns / 1ps
// Signed 64 / unsigned 48 restoring divide, one quotient bit per cycle.
module vcg_divider
    import vcg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  dividend,
    input  logic [WSUM_W-1:0]        divisor,
    output logic                     done,
    output logic signed [SUM_W-1:0]  quotient
);
    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg;
    logic [63:0] q_reg;
    logic [48:0] r_reg;
    logic [47:0] d_reg;
    logic [48:0] r_sh;

    assign r_sh = {r_reg[47:0], q_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            done     <= 1'b0;
        end
        else
        begin
            done <= busy_reg && cnt_reg == 7'd63;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            q_reg   <= dividend[SUM_W-1] ? 64'(-dividend) : 64'(dividend);
            r_reg   <= 49'd0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_reg <= r_sh - {1'b0, d_reg};
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign quotient = neg_reg ? -q_reg : q_reg;
endmodule

// ===== verif/gridder_checker.sv =====
`timescale 1ns / 1ps
module gridder_checker
    import vcg_pkg::*;
#(
    parameter int   GRID_SIDE = 256,
    parameter logic FUNC_READ = 1'b1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               func,
    input  logic signed [31:0] u_meters,
    input  logic signed [31:0] v_meters,
    input  logic [29:0]        freq_khz,
    input  logic signed [31:0] vis_real,
    input  logic signed [31:0] vis_imag,
    input  logic [31:0]        vis_weight,
    input  logic [7:0]         read_row,
    input  logic [7:0]         read_col,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [47:0]        cfg_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic signed [63:0] avg_real,
    input  logic signed [63:0] avg_imag,
    input  logic [47:0]        cell_weight,
    output int                 fail_cnt,
    output int                 pending,
    output int                 accum_cnt,
    output int                 drop_cnt,
    output int                 read_cnt
);

    typedef struct packed {
        logic [1:0]         st;
        logic signed [63:0] re;
        logic signed [63:0] im;
        logic [47:0]        w;
    } cell_result_t;

    logic [SCALE_W-1:0] scale;
    logic signed [63:0] real_acc [int];
    logic signed [63:0] imag_acc [int];
    logic [47:0]        wt_acc [int];
    cell_result_t       expected_q [$];

    // nearest cell along one axis, offset to grid center; sign applied to magnitude
    function automatic longint grid_coord(logic signed [31:0] c, logic [29:0] f);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  hi;
        longint       cells;
        mag = c[31] ? 64'(-64'(c)) : 64'(c);
        prod = 128'(mag * 64'(f)) * 128'(scale);
        hi = prod[127:64];
        cells = longint'((hi + 64'd8192) >> 14);
        return (c[31] ? -cells : cells) + GRID_SIDE / 2;
    endfunction

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic cell_result_t predict_cell();
        cell_result_t r;
        longint row, col;
        int idx;
        logic signed [63:0] wv, sr, si;
        logic [48:0] ws;
        r = '0;
        if (func == FUNC_READ)
        begin
            r.st = ST_READ;
            if (read_row < GRID_SIDE && read_col < GRID_SIDE)
            begin
                idx = int'(read_row) * GRID_SIDE + int'(read_col);
                if (wt_acc.exists(idx))
                begin
                    r.w = wt_acc[idx];
                    r.re = real_acc[idx];
                    r.im = imag_acc[idx];
                    if (r.w != 0)
                    begin
                        r.re = r.re / $signed({16'b0, r.w});
                        r.im = r.im / $signed({16'b0, r.w});
                    end
                end
            end
            return r;
        end
        row = grid_coord(u_meters, freq_khz);
        col = grid_coord(v_meters, freq_khz);
        if (row < 0 || row >= GRID_SIDE || col < 0 || col >= GRID_SIDE)
        begin
            r.st = ST_DROPPED;
            return r;
        end
        idx = int'(row) * GRID_SIDE + int'(col);
        if (!wt_acc.exists(idx))
        begin
            wt_acc[idx] = '0;
            real_acc[idx] = '0;
            imag_acc[idx] = '0;
        end
        wv = $signed({32'b0, vis_weight});
        sr = wv * 64'(vis_real);
        si = wv * 64'(vis_imag);
        real_acc[idx] = sat_sum(real_acc[idx], sr);
        imag_acc[idx] = sat_sum(imag_acc[idx], si);
        ws = {1'b0, wt_acc[idx]} + 49'(vis_weight);
        wt_acc[idx] = ws[48] ? '1 : ws[47:0];
        r.st = ST_ACCUM;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t e;
        if (!rst_n)
        begin
            scale = SCALE_RESET;
            fail_cnt <= 0;
            pending <= 0;
            accum_cnt <= 0;
            drop_cnt <= 0;
            read_cnt <= 0;
        end
        else
        begin
            // result side first: a word accepted this edge cannot answer itself
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word status=%0d", $time, status);
                    fail_cnt <= fail_cnt + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (status !== e.st || avg_real !== e.re || avg_imag !== e.im
                        || cell_weight !== e.w)
                    begin
                        $display("%0t: mismatch exp st=%0d re=%0d im=%0d w=%0d", $time,
                                 e.st, e.re, e.im, e.w);
                        $display("%0t:          got st=%0d re=%0d im=%0d w=%0d", $time,
                                 status, avg_real, avg_imag, cell_weight);
                        fail_cnt <= fail_cnt + 1;
                    end
                    case (e.st)
                        ST_ACCUM:   accum_cnt <= accum_cnt + 1;
                        ST_DROPPED: drop_cnt <= drop_cnt + 1;
                        default:    read_cnt <= read_cnt + 1;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
                scale = cfg_data;
            if (in_valid && in_ready)
                expected_q.push_back(predict_cell());
            pending <= expected_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import vcg_pkg::*;

    localparam logic       FUNC_ACCUM = 1'b0;
    localparam logic       FUNC_READ  = 1'b1;
    localparam int         IDLE_LIMIT = 200000;
    localparam int         SETTLE     = 80;
    localparam logic [7:0] CENTER     = 8'd128;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0, in_ready;
    logic func = FUNC_ACCUM;
    logic signed [31:0] u_meters = '0, v_meters = '0, vis_real = '0, vis_imag = '0;
    logic [29:0] freq_khz = '0;
    logic [31:0] vis_weight = '0;
    logic [7:0] read_row = '0, read_col = '0;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [47:0] cfg_data = '0;
    logic out_valid, out_ready = 1'b0;
    logic [1:0] status;
    logic signed [63:0] avg_real, avg_imag;
    logic [47:0] cell_weight;
    int fail_cnt, pending, accum_cnt, drop_cnt, read_cnt;
    bit idling = 1'b1;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    visibility_cell_gridder u_dut (.*);

    gridder_checker #(.FUNC_READ(FUNC_READ)) u_chk (.*);

    always @(negedge clk)
        out_ready = !idling || ($urandom_range(0, 99) >= 33);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL visibility_cell_gridder");
            $finish;
        end
    end

    task automatic send_word(logic f, logic signed [31:0] u, logic signed [31:0] v,
                             logic [29:0] fr, logic signed [31:0] re,
                             logic signed [31:0] im, logic [31:0] w,
                             logic [7:0] row, logic [7:0] col);
        while (idling && $urandom_range(0, 99) < 33)
            @(negedge clk);
        func = f; u_meters = u; v_meters = v; freq_khz = fr;
        vis_real = re; vis_imag = im; vis_weight = w; read_row = row; read_col = col;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_scale(logic [47:0] s);
        drain();
        cfg_data = s;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random value of a random bit length, sign-extended
    function automatic logic signed [31:0] rand_span();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    task automatic random_word();
        logic [29:0] fr;
        logic [31:0] w;
        logic [7:0] row, col;
        if ($urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                row = 8'(CENTER - 8 + $urandom_range(0, 16));
                col = 8'(CENTER - 8 + $urandom_range(0, 16));
            end
            else
            begin
                row = 8'($urandom);
                col = 8'($urandom);
            end
            send_word(FUNC_READ, $urandom, $urandom, 30'($urandom), $urandom, $urandom,
                      $urandom, row, col);
            return;
        end
        case ($urandom_range(0, 4))
            0:       fr = '0;
            1:       fr = '1;
            default: fr = 30'($urandom) >> $urandom_range(0, 29);
        endcase
        case ($urandom_range(0, 5))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom >> $urandom_range(0, 31);
        endcase
        send_word(FUNC_ACCUM, rand_span(), rand_span(), fr, $urandom, $urandom, w,
                  8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        logic [47:0] scales [4];
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset scale
        send_word(FUNC_READ, '0, '0, '0, '0, '0, '0, CENTER, CENTER);
        send_word(FUNC_ACCUM, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, 32'sh7FFF_FFFF,
                  32'sh8000_0000, '1, '0, '0);
        send_word(FUNC_ACCUM, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, 32'sh7FFF_FFFF,
                  32'sh8000_0000, '1, '0, '0);
        send_word(FUNC_READ, '0, '0, '0, '0, '0, '0, CENTER, CENTER);
        send_word(FUNC_ACCUM, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, 32'sd1, -32'sd1, 32'd1,
                  '0, '0);
        send_word(FUNC_ACCUM, 32'sh8000_0000, 32'sh7FFF_FFFF, '1, 32'sd1, -32'sd1, 32'd1,
                  '0, '0);
        send_word(FUNC_ACCUM, 32'sh7FFF_FFFF, 32'sh8000_0000, 30'd1, 32'sd5, -32'sd7, 32'd3,
                  '0, '0);
        send_word(FUNC_ACCUM, 32'sh0100_0000, -32'sh0100_0000, 30'd100000000,
                  32'sh0010_0000, -32'sh0030_0000, 32'h0010_0000, '0, '0);
        send_word(FUNC_ACCUM, 32'sh0100_0000, -32'sh0100_0000, 30'd100000000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0, '0);
        send_word(FUNC_ACCUM, -32'sh0200_0000, 32'sh0000_4000, 30'd230000000,
                  -32'sh0001_0000, 32'sh0002_0000, 32'h0000_0003, '0, '0);
        send_word(FUNC_READ, '0, '0, '0, '0, '0, '0, 8'd152, 8'd104);
        send_word(FUNC_READ, '0, '0, '0, '0, '0, '0, 8'd255, 8'd0);
        send_word(FUNC_READ, '0, '0, '0, '0, '0, '0, 8'd0, 8'd255);
        send_word(FUNC_READ, '1, '1, '1, '1, '1, '1, 8'd255, 8'd255);

        // saturate the center cell's sums; no idling on either side here
        drain();
        idling = 1'b0;
        repeat (100)
            send_word(FUNC_ACCUM, '0, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, '0, '0);
        send_word(FUNC_READ, '0, '0, '0, '0, '0, '0, CENTER, CENTER);
        idling = 1'b1;

        scales[0] = '0;
        scales[1] = '1;
        scales[2] = 48'($urandom) << 16 | 48'($urandom);
        scales[3] = SCALE_RESET;
        for (int p = 0; p < 4; p++)
        begin
            write_scale(scales[p]);
            for (int i = 0; i < 250; i++)
            begin
                if (p == 2 && i == 125)
                    drain();
                random_word();
            end
        end

        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        $display("covered %0d accumulates, %0d dropped outside grid, %0d cell reads",
                 accum_cnt, drop_cnt, read_cnt);
        $display("cell scale settings: reset, zero, full scale, random");
        if (fail_cnt == 0)
            $display("PASS visibility_cell_gridder");
        else
            $display("FAIL visibility_cell_gridder");
        $finish;
    end

endmodule
